### hw/rtl/ntf_pkg.sv
package ntf_pkg;

  // rolling hash base
  localparam logic [63:0] HASH_BASE = 64'd257;

  // request kinds
  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_LOAD = 1'b1
  } req_kind_t;

  // input transaction payload
  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  coef_index;
    logic [31:0] coef_mult;
    logic [31:0] coef_add;
  } req_t;

  // output transaction payload
  typedef struct packed {
    logic [3:0]  feature_index;
    logic [63:0] feature_value;
    logic        last_feature;
  } feat_t;

  // item travelling down the cell row; word holds the fingerprint,
  // or {mult, add} for a coefficient load
  typedef struct packed {
    logic        valid;
    logic        score;
    logic        load;
    logic        last;
    logic [3:0]  idx;
    logic [63:0] word;
  } item_t;

  // feature handed out by a cell at end of chunk
  typedef struct packed {
    logic        valid;
    logic [63:0] value;
  } emit_t;

  // 257^(n-1) mod 2^64
  function automatic logic [63:0] top_power(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 1; k < n; k++) begin
      p = p * HASH_BASE;
    end
    return p;
  endfunction

endpackage

### hw/rtl/ntf_stream_if.sv
interface ntf_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

### hw/rtl/ntf_hash.sv
module ntf_hash #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           fire,
  input  ntf_pkg::req_t  req_data,
  output ntf_pkg::item_t item_q
);

  localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam logic [63:0] TOP = ntf_pkg::top_power(WINDOW_BYTES);

  logic [CNT_W-1:0] seen;
  logic [63:0]      hash;
  logic [63:0]      drop;
  logic [7:0]       win [WINDOW_BYTES];

  logic           is_load;
  logic           data_fire;
  logic           full;
  logic [63:0]    base;
  logic [63:0]    hash_next;
  ntf_pkg::item_t item_next;

  assign is_load   = req_data.req_type == ntf_pkg::REQ_LOAD;
  assign data_fire = fire && !is_load;
  assign full      = seen == CNT_W'(WINDOW_BYTES);

  // remove oldest byte once the window is full, then roll in the new one
  assign base      = full ? (hash - drop) : hash;
  assign hash_next = (base << 8) + base + {56'd0, req_data.data_byte};

  // item for the cell row
  always_comb begin
    item_next.valid = fire;
    item_next.score = !is_load && full;
    item_next.load  = is_load;
    item_next.last  = !is_load && req_data.last_byte;
    item_next.idx   = req_data.coef_index;
    item_next.word  = is_load ? {req_data.coef_mult, req_data.coef_add} : hash;
  end

  // hash state and front register
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      hash   <= '0;
      item_q <= '0;
    end else begin
      if (adv) begin
        item_q <= item_next;
      end
      if (data_fire) begin
        if (req_data.last_byte) begin
          seen <= '0;
          hash <= '0;
        end else begin
          hash <= hash_next;
          if (!full) begin
            seen <= seen + CNT_W'(1);
          end
        end
      end
    end
  end

  // byte window and precomputed drop term for the next byte
  always_ff @(posedge clk) begin
    if (data_fire) begin
      drop <= TOP * {56'd0, win[1]};
      for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[WINDOW_BYTES-1] <= req_data.data_byte;
    end
  end

endmodule

### hw/rtl/ntf_cell.sv
module ntf_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  ntf_pkg::item_t item_in,
  output ntf_pkg::item_t item_q,
  output ntf_pkg::emit_t emit
);

  localparam logic [3:0] MY_IDX = 4'(CELL_INDEX);

  logic [31:0] mult;
  logic [31:0] add;
  logic [31:0] score;
  logic [31:0] best_score;
  logic [63:0] best_print;

  logic        hit;
  logic        better;
  logic [31:0] score_next;

  assign hit        = item_in.valid && item_in.load && (item_in.idx == MY_IDX);
  assign score_next = mult * item_in.word[31:0] + add;
  assign better     = item_q.valid && item_q.score && (score > best_score);

  // feature goes out with the chunk's last item
  assign emit.valid = item_q.valid && item_q.last;
  assign emit.value = better ? item_q.word : best_print;

  // coefficients, best tracker and item hand-on
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q     <= '0;
      mult       <= '0;
      add        <= '0;
      best_score <= '0;
      best_print <= '0;
    end else if (adv) begin
      item_q <= item_in;
      if (hit) begin
        mult <= item_in.word[63:32];
        add  <= item_in.word[31:0];
      end
      if (emit.valid) begin
        best_score <= '0;
        best_print <= '0;
      end else if (better) begin
        best_score <= score;
        best_print <= item_q.word;
      end
    end
  end

  // transformed score of the arriving fingerprint
  always_ff @(posedge clk) begin
    if (adv) begin
      score <= score_next;
    end
  end

endmodule

### hw/rtl/ntf_out_fifo.sv
module ntf_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ntf_pkg::feat_t push_data,
  output logic           space,
  ntf_stream_if.source   feat
);

  ntf_pkg::feat_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           pop;

  assign space        = count != 2'd2;
  assign feat.valid   = count != 2'd0;
  assign feat.payload = mem[rd_ptr];
  assign pop          = feat.valid && feat.ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/ntransform_feature_extractor.sv
// channel  dir  payload  transaction
// -------  ---  -------  -----------------------------------------------
// req      in   req_t    one chunk byte or one coefficient load
// feat     out  feat_t   one feature; NUM_FEATURES per chunk, in order
//
// one req transaction per cycle while the output buffer has space, set by
// the single-step rolling hash update and the one-multiplier cells; cell i
// hands out feature i once the chunk's last item is in its register; a last
// byte waits while an earlier chunk end is still in the row
// a stalled feat output stops the whole row once the two-entry buffer fills
// synchronous reset clears hash, byte count, coefficients and best values
module ntransform_feature_extractor #(
  parameter int WINDOW_BYTES = 48,
  parameter int NUM_FEATURES = 12
) (
  input  logic         clk,
  input  logic         rst,
  ntf_stream_if.sink   req,
  ntf_stream_if.source feat
);

  ntf_pkg::item_t chain [NUM_FEATURES+1];
  ntf_pkg::emit_t emits [NUM_FEATURES];
  ntf_pkg::feat_t push_data;

  logic adv;
  logic fire;
  logic last_busy;
  logic any_emit;
  logic is_last_req;

  // row advances whenever the output buffer can take a feature
  assign is_last_req = (req.payload.req_type == ntf_pkg::REQ_DATA) && req.payload.last_byte;
  assign req.ready   = adv && !(is_last_req && last_busy);
  assign fire        = req.valid && req.ready;

  // chunk end still in flight
  always_comb begin
    last_busy = 1'b0;
    for (int i = 0; i <= NUM_FEATURES; i++) begin
      last_busy = last_busy | (chain[i].valid && chain[i].last);
    end
  end

  // front end: rolling hash and byte window
  ntf_hash #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_hash (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .fire    (fire),
    .req_data(req.payload),
    .item_q  (chain[0])
  );

  // one cell per transform
  for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_cell
    ntf_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .item_in(chain[g]),
      .item_q (chain[g+1]),
      .emit   (emits[g])
    );
  end

  // at most one cell hands out a feature per cycle
  always_comb begin
    any_emit                = 1'b0;
    push_data.feature_index = '0;
    push_data.feature_value = '0;
    push_data.last_feature  = 1'b0;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      if (emits[i].valid) begin
        any_emit                = 1'b1;
        push_data.feature_index = 4'(i);
        push_data.feature_value = emits[i].value;
        push_data.last_feature  = (i == NUM_FEATURES - 1);
      end
    end
  end

  // output buffer
  ntf_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (adv && any_emit),
    .push_data(push_data),
    .space    (adv),
    .feat     (feat)
  );

endmodule
